### sv/shelf_rectangle_packer_core_assert.svh
// Assertion macros shared by the checker of the shelf packer.
`ifndef SHELF_RECTANGLE_PACKER_CORE_ASSERT_SVH
`define SHELF_RECTANGLE_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SRP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

// Implication checked at every edge, reset included.
`define SRP_ASSERT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |-> (rhs)) \
      else $error("assertion failed");

`endif

### sv/srp_pkg.sv
// Types and constants of the shelf rectangle packer.
`timescale 1ns / 1ps
package srp_pkg;
   localparam int DIM_W   = 13;
   localparam int TAG_W   = 6;
   localparam int PAD_W   = 4;
   localparam int POS_W   = 12;
   localparam int ACC_W   = 16;
   localparam int IDX_W   = 2;

   localparam logic [IDX_W-1:0] REG_START_SIZE = 2'd0;
   localparam logic [IDX_W-1:0] REG_MAX_SIZE   = 2'd1;
   localparam logic [IDX_W-1:0] REG_PAD_PIXELS = 2'd2;

   localparam logic [DIM_W-1:0] START_SIZE_RESET = 13'd512;
   localparam logic [DIM_W-1:0] MAX_SIZE_RESET   = 13'd4096;
   localparam logic [PAD_W-1:0] PAD_RESET        = 4'd1;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [TAG_W-1:0] tag;
   } rect_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      rect_type      new_rect;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_TRY,
      ST_EMIT,
      ST_FAIL
   } state_type;
endpackage

### sv/shelf_rectangle_packer_core.sv
// Shelf rectangle packer: loads one rectangle per cycle into a sorted cell chain.
// Results are registered; after the last rectangle's transfer the core tries edges
// from the start size upward by doubling, unless the set fails at once.
// Throughput: one rectangle per cycle while loading, then one result per cycle
// unless stalled; input stalls from the last transfer until the final result.
// Reset (synchronous, active high) clears the set count, overflow flag and output
// valid, and loads the register defaults 512, 4096 and 1.
`timescale 1ns / 1ps
module shelf_rectangle_packer_core
   import srp_pkg::*;
#(
   parameter int MAX_RECTS = 64
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [DIM_W-1:0] req_rect_width,
   input  logic [DIM_W-1:0] req_rect_height,
   input  logic [TAG_W-1:0] req_rect_tag,
   input  logic             req_last_rect,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic [POS_W-1:0] rsp_pos_x,
   output logic [POS_W-1:0] rsp_pos_y,
   output logic [DIM_W-1:0] rsp_atlas_edge,
   output logic             rsp_pack_failed,
   output logic             rsp_last_out,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);
   localparam int CW = $clog2(MAX_RECTS + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in, step_ff, step_in;
   logic             ovf_ff, ovf_in;
   logic [ACC_W-1:0] edge_ff, edge_in;
   logic [DIM_W-1:0] start_ff, max_ff;
   logic [PAD_W-1:0] pad_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [DIM_W-1:0] edge_out_ff, edge_out_in;
   logic             failed_ff, failed_in, last_ff, last_in;

   cell_ctrl_type ctrl;
   rect_type      cell_rect [MAX_RECTS];
   logic          cell_ins  [MAX_RECTS];
   rect_type      head;

   logic             shelf_clear, shelf_step, fail_now, fail_any;
   logic [POS_W-1:0] sh_x, sh_y;

   logic             accept, full, adv, last_step;
   logic [ACC_W-1:0] first_edge, max_x, dbl_edge;

   assign head = cell_rect[0];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_RECTS; gi++) begin : g_cell
         rect_type lrect, rrect;
         logic     lins, rvalid;
         if (gi == 0) begin : g_first
            assign lrect = '0;
            assign lins  = 1'b0;
         end else begin : g_mid
            assign lrect = cell_rect[gi-1];
            assign lins  = cell_ins[gi-1];
         end
         if (gi == MAX_RECTS - 1) begin : g_tail
            assign rrect  = head;
            assign rvalid = 1'b0;
         end else begin : g_body
            assign rrect  = cell_rect[gi+1];
            assign rvalid = count_ff > CW'(gi + 1);
         end
         srp_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .own_valid   (count_ff > CW'(gi)),
            .left_rect   (lrect),
            .left_ins    (lins),
            .right_rect  (rrect),
            .right_valid (rvalid),
            .head_rect   (head),
            .rect        (cell_rect[gi]),
            .ins         (cell_ins[gi])
         );
      end
   endgenerate

   srp_shelf u_shelf (
      .clock    (clock),
      .clear    (shelf_clear),
      .step     (shelf_step),
      .rect     (head),
      .pad      (pad_ff),
      .edge_len (edge_ff),
      .pos_x    (sh_x),
      .pos_y    (sh_y),
      .fail_now (fail_now),
      .fail_any (fail_any)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_SIZE_RESET;
         max_ff   <= MAX_SIZE_RESET;
         pad_ff   <= PAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_SIZE: start_ff <= csr_wdata;
            REG_MAX_SIZE:   max_ff   <= csr_wdata;
            REG_PAD_PIXELS: pad_ff   <= csr_wdata[PAD_W-1:0];
            default:        ;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_LOAD);
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CW'(MAX_RECTS));
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign last_step  = (step_ff == count_ff - CW'(1));
   assign first_edge = (start_ff == '0) ? ACC_W'(1) : ACC_W'(start_ff);
   assign max_x      = ACC_W'(max_ff);
   assign dbl_edge   = {edge_ff[ACC_W-2:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      edge_in      = edge_ff;
      ctrl.mode    = CELL_HOLD;
      ctrl.new_rect = '{width: req_rect_width, height: req_rect_height, tag: req_rect_tag};
      shelf_clear  = 1'b0;
      shelf_step   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_in       = tag_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      edge_out_in  = edge_out_ff;
      failed_in    = failed_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ctrl.mode = CELL_INSERT;
                  count_in  = count_ff + CW'(1);
               end
               if (req_last_rect) begin
                  edge_in     = first_edge;
                  step_in     = '0;
                  shelf_clear = 1'b1;
                  if (ovf_ff || full || (first_edge > max_x)) begin
                     state_in = ST_FAIL;
                  end else begin
                     state_in = ST_TRY;
                  end
               end
            end
         end
         ST_TRY: begin
            ctrl.mode  = CELL_ROTATE;
            shelf_step = 1'b1;
            step_in    = step_ff + CW'(1);
            if (last_step) begin
               step_in     = '0;
               shelf_clear = 1'b1;
               if (!fail_any) begin
                  state_in = ST_EMIT;
               end else if (dbl_edge > max_x) begin
                  state_in = ST_FAIL;
               end else begin
                  edge_in = dbl_edge;
               end
            end
         end
         ST_EMIT: begin
            if (adv) begin
               ctrl.mode    = CELL_ROTATE;
               shelf_step   = 1'b1;
               step_in      = step_ff + CW'(1);
               rsp_valid_in = 1'b1;
               tag_in       = head.tag;
               px_in        = sh_x;
               py_in        = sh_y;
               edge_out_in  = edge_ff[DIM_W-1:0];
               failed_in    = 1'b0;
               last_in      = last_step;
               if (last_step) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         ST_FAIL: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               tag_in       = '0;
               px_in        = '0;
               py_in        = '0;
               edge_out_in  = '0;
               failed_in    = 1'b1;
               last_in      = 1'b1;
               state_in     = ST_LOAD;
               count_in     = '0;
               ovf_in       = 1'b0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      edge_ff     <= edge_in;
      tag_ff      <= tag_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      edge_out_ff <= edge_out_in;
      failed_ff   <= failed_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_tag     = tag_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_atlas_edge  = edge_out_ff;
   assign rsp_pack_failed = failed_ff;
   assign rsp_last_out    = last_ff;
endmodule

### sv/srp_cell.sv
// One cell of the sorted rectangle chain: stable insert by height and rotate.
`timescale 1ns / 1ps
module srp_cell
   import srp_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          own_valid,
   input  rect_type      left_rect,
   input  logic          left_ins,
   input  rect_type      right_rect,
   input  logic          right_valid,
   input  rect_type      head_rect,
   output rect_type      rect,
   output logic          ins
);
   rect_type rect_ff, rect_in;

   // A new rectangle goes in front of the first strictly lower one, so equal
   // heights keep load order.
   assign ins = !own_valid || (rect_ff.height < ctrl.new_rect.height);

   always_comb begin
      rect_in = rect_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (left_ins) begin
               rect_in = left_rect;
            end else if (ins) begin
               rect_in = ctrl.new_rect;
            end
         end
         CELL_ROTATE: begin
            rect_in = right_valid ? right_rect : head_rect;
         end
         default: rect_in = rect_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rect_ff <= rect_in;
   end

   assign rect = rect_ff;
endmodule

### sv/srp_shelf.sv
// Next-fit shelf placement unit: one rectangle per step, sticky fit failure.
`timescale 1ns / 1ps
module srp_shelf
   import srp_pkg::*;
(
   input  logic             clock,
   input  logic             clear,
   input  logic             step,
   input  rect_type         rect,
   input  logic [PAD_W-1:0] pad,
   input  logic [ACC_W-1:0] edge_len,
   output logic [POS_W-1:0] pos_x,
   output logic [POS_W-1:0] pos_y,
   output logic             fail_now,
   output logic             fail_any
);
   logic [ACC_W-1:0] sx_ff, sx_in, sy_ff, sy_in, shelf_ff, shelf_in;
   logic             fail_ff, fail_in;
   logic [ACC_W-1:0] pad_x, w_x, h_x, wpad, nsx, nsy, nshelf;
   logic             wrap, fail_w, fail_h;

   always_comb begin
      pad_x  = ACC_W'(pad);
      w_x    = ACC_W'(rect.width);
      h_x    = ACC_W'(rect.height);
      wpad   = w_x + pad_x;
      wrap   = (sx_ff + wpad) > edge_len;
      nsx    = wrap ? pad_x : sx_ff;
      nsy    = wrap ? (sy_ff + shelf_ff + pad_x) : sy_ff;
      nshelf = wrap ? '0 : shelf_ff;
      fail_w = wrap && ((pad_x + wpad) > edge_len);
      fail_h = (nsy + h_x + pad_x) > edge_len;
      fail_now = fail_w || fail_h;
      fail_any = fail_ff || fail_now;

      sx_in    = sx_ff;
      sy_in    = sy_ff;
      shelf_in = shelf_ff;
      fail_in  = fail_ff;
      if (clear) begin
         sx_in    = pad_x;
         sy_in    = pad_x;
         shelf_in = '0;
         fail_in  = 1'b0;
      end else if (step) begin
         sx_in    = nsx + wpad;
         sy_in    = nsy;
         shelf_in = (h_x > nshelf) ? h_x : nshelf;
         fail_in  = fail_any;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      shelf_ff <= shelf_in;
      fail_ff  <= fail_in;
   end

   assign pos_x = nsx[POS_W-1:0];
   assign pos_y = nsy[POS_W-1:0];
endmodule

### sv/srp_checker.sv
// Port-level checker of the shelf packer and its bind to the top level.
`timescale 1ns / 1ps
`include "shelf_rectangle_packer_core_assert.svh"
module srp_checker
   import srp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [TAG_W-1:0] rsp_out_tag,
   input logic [POS_W-1:0] rsp_pos_x,
   input logic [POS_W-1:0] rsp_pos_y,
   input logic [DIM_W-1:0] rsp_atlas_edge,
   input logic             rsp_pack_failed,
   input logic             rsp_last_out
);
   // A failure is a single, all-zero closing result.
   `SRP_ASSERT_IMPLY(a_fail_form, clock, reset, rsp_valid && rsp_pack_failed, rsp_last_out && rsp_atlas_edge == '0 && rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_out_tag == '0)
   // A placement always names a nonzero square.
   `SRP_ASSERT_IMPLY(a_place_edge, clock, reset, rsp_valid && !rsp_pack_failed, rsp_atlas_edge != '0)
   // A stalled result stays valid, with its position and last flag, until the transfer.
   `SRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_last_out))
   // Nothing is offered right after reset.
   `SRP_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_valid)
endmodule

bind shelf_rectangle_packer_core srp_checker u_srp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_tag     (rsp_out_tag),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_atlas_edge  (rsp_atlas_edge),
   .rsp_pack_failed (rsp_pack_failed),
   .rsp_last_out    (rsp_last_out)
);
